@@ rtl/cwed_pkg.sv @@
// shared types and constants for the closest word edit distance block
// no dependencies; used by every rtl file but cwed_checker through scoped names
package cwed_pkg;

    // distance and column width, sized for words of up to 127 characters
    localparam int DIST_W = 7;

    typedef enum logic [1:0] {
        OP_DICT_CHAR  = 2'd0,
        OP_DICT_INS   = 2'd1,
        OP_QUERY_CHAR = 2'd2,
        OP_QUERY_RUN  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_ADDR,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_INS_WR,
        ST_Q_ADDR,
        ST_Q_STREAM,
        ST_Q_DRAIN,
        ST_Q_OUT
    } state_t;

    // one column of the distance table as it moves from row to row
    typedef struct packed {
        logic              valid;
        logic              tail;
        logic [DIST_W-1:0] col;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] d1;
        logic [DIST_W-1:0] x;
        logic [DIST_W-1:0] x1;
        logic [7:0]        b;
        logic [7:0]        b1;
    } link_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

@@ rtl/cwed_cell.sv @@
// one row of the skewed distance table: computes one entry per cycle
// depends on cwed_pkg (link_t, DIST_W)
module cwed_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cwed_pkg::link_t             prev,
    input  logic [7:0]                  a_cur,
    input  logic [7:0]                  a_prev,
    input  logic [cwed_pkg::DIST_W-1:0] row,
    input  logic                        use_swap,
    output cwed_pkg::link_t             cur
);

    localparam int DW = cwed_pkg::DIST_W;

    cwed_pkg::link_t cur_reg, cur_next;
    logic            vld_reg, tail_reg;
    logic [DW-1:0]   m1, m2, v, s;

    always_comb
    begin
        m1 = (prev.d < cur_reg.d) ? prev.d : cur_reg.d;
        m2 = (m1 < prev.d1) ? m1 : prev.d1;
        s  = prev.x1 + DW'(1);
        if (prev.col == '0)
        begin
            v = row;
        end
        else if (a_cur == prev.b)
        begin
            v = prev.d1;
        end
        else
        begin
            v = m2 + DW'(1);
            // adjacent swap
            if (use_swap && prev.col > DW'(1) && a_cur == prev.b1 && a_prev == prev.b && s < v)
            begin
                v = s;
            end
        end
        cur_next       = cur_reg;
        cur_next.valid = prev.valid;
        cur_next.tail  = prev.tail;
        cur_next.col   = prev.col;
        cur_next.d     = v;
        cur_next.d1    = cur_reg.d;
        cur_next.x     = prev.d1;
        cur_next.x1    = cur_reg.x;
        cur_next.b     = prev.b;
        cur_next.b1    = cur_reg.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= prev.valid;
            tail_reg <= prev.tail;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_comb
    begin
        cur       = cur_reg;
        cur.valid = vld_reg;
        cur.tail  = tail_reg;
    end

endmodule

@@ rtl/cwed_chain.sv @@
// row of distance cells, one per query character, fed by row zero
// depends on cwed_pkg and cwed_cell
module cwed_chain #(
    parameter int MAX_LEN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cwed_pkg::link_t               src,
    input  logic [MAX_LEN-1:0][7:0]       query,
    output cwed_pkg::link_t [MAX_LEN:0]   rows
);

    assign rows[0] = src;

    for (genvar i = 1; i <= MAX_LEN; i++)
    begin : g_cell
        logic [7:0] a_prev;
        if (i > 1)
        begin : g_prev
            assign a_prev = query[i-2];
        end
        else
        begin : g_first
            assign a_prev = 8'd0;
        end
        cwed_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .prev     (rows[i-1]),
            .a_cur    (query[i-1]),
            .a_prev   (a_prev),
            .row      (cwed_pkg::DIST_W'(i)),
            .use_swap (i > 1),
            .cur      (rows[i])
        );
    end

endmodule

@@ rtl/closest_word_edit_distance_core.sv @@
// closest word edit distance core: dictionary store, scan control and cell chain.
// a query streams each stored entry through the cell chain, then sends out the best one
// an insert checks each entry of equal length for a duplicate, then stores a new word
// one command word is taken at a time; results leave through an output register.
// rst_n clears counters, flags and valid bits at once; stores need no clearing pass.
// depends on cwed_pkg and cwed_chain
module closest_word_edit_distance_core #(
    parameter int MAX_LEN      = 16,
    parameter int DICT_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] match_char,
    output logic       char_valid,
    output logic       found,
    output logic       no_match,
    output logic [4:0] edit_distance,
    output logic       overflow,
    output logic       last
);

    localparam int DW    = cwed_pkg::DIST_W;
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int POS_W = $clog2(MAX_LEN);
    localparam int IDX_W = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int CNT_W = $clog2(DICT_ENTRIES + 1);
    localparam int MEM_D = DICT_ENTRIES * (2 ** POS_W);

    cwed_pkg::state_t state_reg, state_next;

    logic [7:0]               pend_chars_reg [MAX_LEN];
    logic [MAX_LEN-1:0][7:0]  query_chars_reg;
    logic [7:0]               bank_reg [2][MAX_LEN];
    logic [7:0]               char_mem [MEM_D];
    logic [LEN_W-1:0]         len_mem [DICT_ENTRIES];
    logic [7:0]               char_rd_reg;
    logic [LEN_W-1:0]         len_rd_reg;

    logic [LEN_W-1:0] pend_len_reg, pend_len_next, query_len_reg, query_len_next;
    logic [LEN_W-1:0] pos_reg, pos_next, best_len_reg, best_len_next;
    logic [CNT_W-1:0] count_reg, count_next, e_reg, e_next;
    logic [DW-1:0]    best_d_reg, best_d_next;
    logic ovf_reg, ovf_next, eq_reg, eq_next, lt_reg, lt_next, gt_reg, gt_next;
    logic found_reg, found_next, sel_reg, sel_next, empty_reg, empty_next;

    logic             out_valid_reg, out_valid_next, out_load;
    logic [7:0]       oc_reg, oc_next;
    logic             ov_reg, ov_next, of_reg, of_next, on_reg, on_next;
    logic [4:0]       od_reg, od_next;
    logic             oo_reg, oo_next, ol_reg, ol_next;

    cwed_pkg::link_t             src_reg, src_next, src;
    logic                        src_vld_reg, src_vld_next, src_tail_reg, src_tail_next;
    cwed_pkg::link_t [MAX_LEN:0] rows;
    cwed_pkg::link_t             sel_row;

    logic             in_fire, out_free, last_entry, better;
    logic [7:0]       fch, cw, bank_rd;
    logic [LEN_W-1:0] km1;
    logic [POS_W-1:0] kp, bank_idx, pos_p;
    logic             pend_we, query_we, bank_we, char_we, len_we;
    logic [IDX_W-1:0] rd_idx, wr_idx;

    assign in_ready   = (state_reg == cwed_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign fch        = cwed_pkg::fold_case(char_code);
    assign km1        = pos_reg - LEN_W'(1);
    assign kp         = km1[POS_W-1:0];
    assign pos_p      = pos_reg[POS_W-1:0];
    assign cw         = char_rd_reg;
    assign rd_idx     = e_reg[IDX_W-1:0];
    assign wr_idx     = count_reg[IDX_W-1:0];
    assign last_entry = (e_reg + CNT_W'(1)) == count_reg;
    assign bank_idx   = (state_reg == cwed_pkg::ST_Q_OUT) ? pos_p : kp;
    assign bank_rd    = bank_reg[sel_reg][bank_idx];
    assign sel_row    = rows[query_len_reg];

    always_comb
    begin
        better = (e_reg == '0) || (sel_row.d < best_d_reg) ||
                 ((sel_row.d == best_d_reg) &&
                  (lt_reg || (!gt_reg && len_rd_reg < best_len_reg)));
    end

    // control path
    always_comb
    begin
        state_next     = state_reg;
        pend_len_next  = pend_len_reg;
        query_len_next = query_len_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        e_next         = e_reg;
        ovf_next       = ovf_reg;
        eq_next        = eq_reg;
        lt_next        = lt_reg;
        gt_next        = gt_reg;
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_d_next    = best_d_reg;
        sel_next       = sel_reg;
        empty_next     = empty_reg;
        pend_we        = 1'b0;
        query_we       = 1'b0;
        bank_we        = 1'b0;
        char_we        = 1'b0;
        len_we         = 1'b0;
        out_load       = 1'b0;
        oc_next        = 8'd0;
        ov_next        = 1'b0;
        of_next        = found_reg;
        on_next        = 1'b0;
        od_next        = best_d_reg[4:0];
        oo_next        = ovf_reg;
        ol_next        = 1'b0;
        src_vld_next   = 1'b0;
        src_tail_next  = 1'b0;
        src_next       = src_reg;
        src_next.col   = DW'(pos_reg);
        src_next.d     = DW'(pos_reg);
        src_next.d1    = src_reg.d;
        src_next.x     = '0;
        src_next.x1    = '0;
        src_next.b     = (pos_reg == '0) ? 8'd0 : cw;
        src_next.b1    = src_reg.b;

        unique case (state_reg)
            cwed_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cwed_pkg::op_t'(op))
                        cwed_pkg::OP_DICT_CHAR:
                        begin
                            if (pend_len_reg < LEN_W'(MAX_LEN))
                            begin
                                pend_we       = 1'b1;
                                pend_len_next = pend_len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        cwed_pkg::OP_QUERY_CHAR:
                        begin
                            if (query_len_reg < LEN_W'(MAX_LEN))
                            begin
                                query_we       = 1'b1;
                                query_len_next = query_len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        cwed_pkg::OP_DICT_INS:
                        begin
                            e_next   = '0;
                            pos_next = '0;
                            state_next = (count_reg == '0) ? cwed_pkg::ST_INS_WR
                                                           : cwed_pkg::ST_INS_ADDR;
                        end
                        cwed_pkg::OP_QUERY_RUN:
                        begin
                            e_next     = '0;
                            pos_next   = '0;
                            found_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                empty_next = 1'b1;
                                state_next = cwed_pkg::ST_Q_OUT;
                            end
                            else
                            begin
                                state_next = cwed_pkg::ST_Q_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = cwed_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            cwed_pkg::ST_INS_ADDR:
            begin
                pos_next   = '0;
                state_next = cwed_pkg::ST_INS_CHK;
            end
            cwed_pkg::ST_INS_CHK:
            begin
                if (len_rd_reg == pend_len_reg)
                begin
                    pos_next   = LEN_W'(1);
                    state_next = cwed_pkg::ST_INS_CMP;
                end
                else if (last_entry)
                begin
                    pos_next   = '0;
                    state_next = cwed_pkg::ST_INS_WR;
                end
                else
                begin
                    e_next     = e_reg + CNT_W'(1);
                    state_next = cwed_pkg::ST_INS_ADDR;
                end
            end
            cwed_pkg::ST_INS_CMP:
            begin
                if (pos_reg > pend_len_reg)
                begin
                    // duplicate word, nothing stored
                    pend_len_next = '0;
                    state_next    = cwed_pkg::ST_IDLE;
                end
                else if (cw != pend_chars_reg[kp])
                begin
                    if (last_entry)
                    begin
                        pos_next   = '0;
                        state_next = cwed_pkg::ST_INS_WR;
                    end
                    else
                    begin
                        e_next     = e_reg + CNT_W'(1);
                        state_next = cwed_pkg::ST_INS_ADDR;
                    end
                end
                else
                begin
                    pos_next = pos_reg + LEN_W'(1);
                end
            end
            cwed_pkg::ST_INS_WR:
            begin
                if (count_reg == CNT_W'(DICT_ENTRIES))
                begin
                    ovf_next      = 1'b1;
                    pend_len_next = '0;
                    state_next    = cwed_pkg::ST_IDLE;
                end
                else if (pos_reg < pend_len_reg)
                begin
                    char_we  = 1'b1;
                    pos_next = pos_reg + LEN_W'(1);
                end
                else
                begin
                    len_we        = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    pend_len_next = '0;
                    state_next    = cwed_pkg::ST_IDLE;
                end
            end
            cwed_pkg::ST_Q_ADDR:
            begin
                pos_next   = '0;
                state_next = cwed_pkg::ST_Q_STREAM;
            end
            cwed_pkg::ST_Q_STREAM:
            begin
                src_vld_next  = 1'b1;
                src_tail_next = (pos_reg == len_rd_reg);
                if (pos_reg == '0)
                begin
                    eq_next = (query_len_reg == len_rd_reg);
                    lt_next = 1'b0;
                    gt_next = 1'b0;
                end
                else
                begin
                    bank_we = 1'b1;
                    if (cw != query_chars_reg[kp])
                    begin
                        eq_next = 1'b0;
                    end
                    // lexicographic order against the current best entry
                    if (!lt_reg && !gt_reg && km1 < best_len_reg)
                    begin
                        lt_next = (cw < bank_rd);
                        gt_next = (cw > bank_rd);
                    end
                end
                if (pos_reg == len_rd_reg)
                begin
                    state_next = cwed_pkg::ST_Q_DRAIN;
                end
                else
                begin
                    pos_next = pos_reg + LEN_W'(1);
                end
            end
            cwed_pkg::ST_Q_DRAIN:
            begin
                if (sel_row.valid && sel_row.tail)
                begin
                    if (better)
                    begin
                        sel_next      = !sel_reg;
                        best_len_next = len_rd_reg;
                        best_d_next   = sel_row.d;
                    end
                    found_next = found_reg || eq_reg;
                    pos_next   = '0;
                    if (last_entry)
                    begin
                        state_next = cwed_pkg::ST_Q_OUT;
                    end
                    else
                    begin
                        e_next     = e_reg + CNT_W'(1);
                        state_next = cwed_pkg::ST_Q_ADDR;
                    end
                end
            end
            cwed_pkg::ST_Q_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (empty_reg)
                    begin
                        of_next = 1'b0;
                        on_next = 1'b1;
                        od_next = 5'd0;
                        ol_next = 1'b1;
                    end
                    else
                    begin
                        ov_next = (best_len_reg != '0);
                        oc_next = (best_len_reg != '0) ? bank_rd : 8'd0;
                        ol_next = (best_len_reg == '0) ||
                                  ((pos_reg + LEN_W'(1)) == best_len_reg);
                    end
                    if (ol_next)
                    begin
                        empty_next     = 1'b0;
                        query_len_next = '0;
                        state_next     = cwed_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + LEN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = cwed_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwed_pkg::ST_IDLE;
            pend_len_reg  <= '0;
            query_len_reg <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            e_reg         <= '0;
            ovf_reg       <= 1'b0;
            eq_reg        <= 1'b0;
            lt_reg        <= 1'b0;
            gt_reg        <= 1'b0;
            found_reg     <= 1'b0;
            best_len_reg  <= '0;
            best_d_reg    <= '0;
            sel_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            src_vld_reg   <= 1'b0;
            src_tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_len_reg  <= pend_len_next;
            query_len_reg <= query_len_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            e_reg         <= e_next;
            ovf_reg       <= ovf_next;
            eq_reg        <= eq_next;
            lt_reg        <= lt_next;
            gt_reg        <= gt_next;
            found_reg     <= found_next;
            best_len_reg  <= best_len_next;
            best_d_reg    <= best_d_next;
            sel_reg       <= sel_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            src_vld_reg   <= src_vld_next;
            src_tail_reg  <= src_tail_next;
        end
    end

    // word buffers, best-entry banks, dictionary stores and the output register
    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        char_rd_reg <= char_mem[{rd_idx, pos_p}];
        len_rd_reg  <= len_mem[rd_idx];
        if (pend_we)
        begin
            pend_chars_reg[pend_len_reg[POS_W-1:0]] <= fch;
        end
        if (query_we)
        begin
            query_chars_reg[query_len_reg[POS_W-1:0]] <= fch;
        end
        if (bank_we)
        begin
            bank_reg[!sel_reg][kp] <= cw;
        end
        if (char_we)
        begin
            char_mem[{wr_idx, pos_p}] <= pend_chars_reg[pos_p];
        end
        if (len_we)
        begin
            len_mem[wr_idx] <= pend_len_reg;
        end
        if (out_load)
        begin
            oc_reg <= oc_next;
            ov_reg <= ov_next;
            of_reg <= of_next;
            on_reg <= on_next;
            od_reg <= od_next;
            oo_reg <= oo_next;
            ol_reg <= ol_next;
        end
    end

    always_comb
    begin
        src       = src_reg;
        src.valid = src_vld_reg;
        src.tail  = src_tail_reg;
    end

    cwed_chain #(
        .MAX_LEN (MAX_LEN)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .query (query_chars_reg),
        .rows  (rows)
    );

    assign out_valid     = out_valid_reg;
    assign match_char    = oc_reg;
    assign char_valid    = ov_reg;
    assign found         = of_reg;
    assign no_match      = on_reg;
    assign edit_distance = od_reg;
    assign overflow      = oo_reg;
    assign last          = ol_reg;

endmodule

@@ rtl/cwed_checker.sv @@
// port-level checks for the closest word edit distance core, and its bind
// depends only on the top level's ports
module cwed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       char_valid,
    input logic       found,
    input logic       no_match,
    input logic [4:0] edit_distance,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_empty_dict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_match |-> last && !char_valid && !found && edit_distance == 5'd0)
        else $error("empty dictionary word malformed");

    a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> last)
        else $error("empty match must be a single word");

    a_exact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> edit_distance == 5'd0)
        else $error("exact hit with nonzero distance");

endmodule

bind closest_word_edit_distance_core cwed_checker u_cwed_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .char_valid    (char_valid),
    .found         (found),
    .no_match      (no_match),
    .edit_distance (edit_distance),
    .last          (last)
);

@@ tb/closest_word_edit_distance_core_tb.sv @@
// testbench for closest_word_edit_distance_core: drives dictionary and query words,
// predicts each result word with a behavioral distance model and checks them in order
// depends on cwed_pkg and the core rtl
`timescale 1ns / 100ps

module closest_word_edit_distance_core_tb;

    localparam int MAX_LEN      = 16;
    localparam int DICT_ENTRIES = 256;
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct {
        logic [7:0] match_char;
        logic       char_valid;
        logic       found;
        logic       no_match;
        logic [4:0] edit_distance;
        logic       overflow;
        logic       last;
    } result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [7:0] char_code;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] match_char;
    logic       char_valid;
    logic       found;
    logic       no_match;
    logic [4:0] edit_distance;
    logic       overflow;
    logic       last;

    // predictor state
    byte unsigned dict_words[$][$];
    byte unsigned dict_pending[$];
    byte unsigned query_word[$];
    bit           overflow_flag;

    result_t expected_results[$];
    int          error_count;
    int          cycle_count;

    closest_word_edit_distance_core #(
        .MAX_LEN(MAX_LEN),
        .DICT_ENTRIES(DICT_ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .char_code(char_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .match_char(match_char),
        .char_valid(char_valid),
        .found(found),
        .no_match(no_match),
        .edit_distance(edit_distance),
        .overflow(overflow),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic byte unsigned lower_byte(input byte unsigned c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic bit words_equal(input byte unsigned a[$], input byte unsigned b[$]);
        if (a.size() != b.size())
        begin
            return 1'b0;
        end
        foreach (a[k])
        begin
            if (a[k] != b[k])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit word_before(input byte unsigned a[$], input byte unsigned b[$]);
        for (int k = 0; k < a.size() && k < b.size(); k++)
        begin
            if (a[k] != b[k])
            begin
                return a[k] < b[k];
            end
        end
        return a.size() < b.size();
    endfunction

    // optimal string alignment distance over a full table
    function automatic int osa_dist(input byte unsigned a[$], input byte unsigned b[$]);
        int t[MAX_LEN+1][MAX_LEN+1];
        int n;
        int m;
        int v;
        n = a.size();
        m = b.size();
        for (int i = 0; i <= n; i++)
        begin
            for (int j = 0; j <= m; j++)
            begin
                if (i == 0)
                begin
                    v = j;
                end
                else if (j == 0)
                begin
                    v = i;
                end
                else if (a[i-1] == b[j-1])
                begin
                    v = t[i-1][j-1];
                end
                else
                begin
                    v = t[i-1][j];
                    if (t[i][j-1] < v) v = t[i][j-1];
                    if (t[i-1][j-1] < v) v = t[i-1][j-1];
                    v = v + 1;
                    if (i > 1 && j > 1 && a[i-1] == b[j-2] && a[i-2] == b[j-1]
                        && t[i-2][j-2] + 1 < v)
                    begin
                        v = t[i-2][j-2] + 1;
                    end
                end
                t[i][j] = v;
            end
        end
        return t[n][m];
    endfunction

    // advance the predictor by one command word
    task automatic predict_word(input cwed_pkg::op_t cmd, input byte unsigned code);
        byte unsigned c;
        bit           dup;
        int           best;
        int           best_d;
        int           d;
        bit           hit;
        result_t      r;
        byte unsigned bw[$];
        c = lower_byte(code);
        case (cmd)
            cwed_pkg::OP_DICT_CHAR:
            begin
                if (dict_pending.size() < MAX_LEN) dict_pending.push_back(c);
                else overflow_flag = 1'b1;
            end
            cwed_pkg::OP_QUERY_CHAR:
            begin
                if (query_word.size() < MAX_LEN) query_word.push_back(c);
                else overflow_flag = 1'b1;
            end
            cwed_pkg::OP_DICT_INS:
            begin
                dup = 1'b0;
                foreach (dict_words[e])
                begin
                    if (words_equal(dict_words[e], dict_pending)) dup = 1'b1;
                end
                if (!dup)
                begin
                    if (dict_words.size() < DICT_ENTRIES) dict_words.push_back(dict_pending);
                    else overflow_flag = 1'b1;
                end
                dict_pending.delete();
            end
            default:
            begin
                r.overflow = overflow_flag;
                r.no_match = 1'b0;
                r.found = 1'b0;
                r.match_char = 8'd0;
                r.char_valid = 1'b0;
                r.last = 1'b1;
                r.edit_distance = 5'd0;
                if (dict_words.size() == 0)
                begin
                    r.no_match = 1'b1;
                    expected_results.push_back(r);
                end
                else
                begin
                    best = 0;
                    best_d = 0;
                    hit = 1'b0;
                    foreach (dict_words[e])
                    begin
                        d = osa_dist(query_word, dict_words[e]);
                        if (words_equal(query_word, dict_words[e])) hit = 1'b1;
                        if (e == 0 || d < best_d
                            || (d == best_d && word_before(dict_words[e], dict_words[best])))
                        begin
                            best = e;
                            best_d = d;
                        end
                    end
                    r.found = hit;
                    r.edit_distance = best_d[4:0];
                    bw = dict_words[best];
                    if (bw.size() == 0)
                    begin
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        for (int k = 0; k < bw.size(); k++)
                        begin
                            r.match_char = bw[k];
                            r.char_valid = 1'b1;
                            r.last = (k == bw.size() - 1);
                            expected_results.push_back(r);
                        end
                    end
                end
                query_word.delete();
            end
        endcase
    endtask

    // send one command word after a random gap; valid drops only when a gap follows
    task automatic send_word(input cwed_pkg::op_t cmd, input byte unsigned code,
                             input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            op <= cwed_pkg::op_t'($urandom_range(0, 3));
            char_code <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= cmd;
        char_code <= code;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(cmd, code);
    endtask

    task automatic send_string(input cwed_pkg::op_t cmd, input string s);
        for (int k = 0; k < s.len(); k++) send_word(cmd, s[k]);
    endtask

    task automatic add_entry(input string s);
        send_string(cwed_pkg::OP_DICT_CHAR, s);
        send_word(cwed_pkg::OP_DICT_INS, 8'd0);
    endtask

    task automatic run_query(input string s);
        send_string(cwed_pkg::OP_QUERY_CHAR, s);
        send_word(cwed_pkg::OP_QUERY_RUN, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        op <= cwed_pkg::op_t'($urandom_range(0, 3));
        char_code <= 8'($urandom_range(0, 255));
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_dictionary();
        run_query("abc");
        run_query("");
    endtask

    task automatic test_directed_words();
        add_entry("Cat");
        add_entry("cat");
        add_entry("");
        add_entry("act");
        run_query("CAT");
        run_query("tac");
        run_query("");
        run_query("bat");
    endtask

    task automatic test_extreme_bytes();
        send_word(cwed_pkg::OP_DICT_CHAR, 8'hFF);
        send_word(cwed_pkg::OP_DICT_CHAR, 8'h00);
        send_word(cwed_pkg::OP_DICT_CHAR, 8'h5A);
        send_word(cwed_pkg::OP_DICT_INS, 8'hFF);
        send_word(cwed_pkg::OP_QUERY_CHAR, 8'hFF);
        send_word(cwed_pkg::OP_QUERY_CHAR, 8'h7A);
        send_word(cwed_pkg::OP_QUERY_RUN, 8'h00);
        wait_drained();
    endtask

    task automatic test_long_word();
        for (int k = 0; k < MAX_LEN + 2; k++)
            send_word(cwed_pkg::OP_DICT_CHAR, 8'(8'h61 + k), 1);
        send_word(cwed_pkg::OP_DICT_INS, 8'd0);
        for (int k = 0; k < MAX_LEN + 1; k++)
            send_word(cwed_pkg::OP_QUERY_CHAR, 8'(8'h61 + k), 1);
        send_word(cwed_pkg::OP_QUERY_RUN, 8'd0);
        wait_drained();
    endtask

    // mostly words over a small alphabet so that ties, swaps and duplicates happen
    task automatic test_random_words();
        int len;
        int kind;
        byte unsigned c;
        for (int n = 0; n < 14; n++)
        begin
            kind = $urandom_range(0, 9);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN)
                                               : $urandom_range(0, 5);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
                else c = 8'(8'h61 + $urandom_range(0, 3)
                            - ($urandom_range(0, 3) == 0 ? 32 : 0));
                send_word(kind < 5 ? cwed_pkg::OP_DICT_CHAR : cwed_pkg::OP_QUERY_CHAR, c);
            end
            if (kind < 5) send_word(cwed_pkg::OP_DICT_INS, 8'($urandom_range(0, 255)));
            else if (kind < 9) send_word(cwed_pkg::OP_QUERY_RUN, 8'($urandom_range(0, 255)));
            else send_word(cwed_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            if (n == 7) wait_drained();
        end
    endtask

    // receiver side: random wait per word, compare each accepted word with the oldest one
    initial
    begin
        result_t x;
        int      hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, 8);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                x = expected_results.pop_front();
                if (match_char !== x.match_char)
                begin
                    $error("match_char exp %0h got %0h", x.match_char, match_char);
                    error_count++;
                end
                if (char_valid !== x.char_valid)
                begin
                    $error("char_valid exp %0d got %0d", x.char_valid, char_valid);
                    error_count++;
                end
                if (found !== x.found)
                begin
                    $error("found exp %0d got %0d", x.found, found);
                    error_count++;
                end
                if (no_match !== x.no_match)
                begin
                    $error("no_match exp %0d got %0d", x.no_match, no_match);
                    error_count++;
                end
                if (edit_distance !== x.edit_distance)
                begin
                    $error("edit_distance exp %0d got %0d", x.edit_distance,
                           edit_distance);
                    error_count++;
                end
                if (overflow !== x.overflow)
                begin
                    $error("overflow exp %0d got %0d", x.overflow, overflow);
                    error_count++;
                end
                if (last !== x.last)
                begin
                    $error("last exp %0d got %0d", x.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = cwed_pkg::OP_DICT_CHAR;
        char_code = 8'd0;
        error_count = 0;
        cycle_count = 0;
        overflow_flag = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_dictionary();
        test_directed_words();
        test_extreme_bytes();
        test_random_words();
        test_long_word();
        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ closest_word_edit_distance_core.f @@
rtl/cwed_pkg.sv
rtl/cwed_cell.sv
rtl/cwed_chain.sv
rtl/closest_word_edit_distance_core.sv
rtl/cwed_checker.sv
tb/closest_word_edit_distance_core_tb.sv
